@@ rtl/bps_pkg.sv @@
`default_nettype none

package bps_pkg;

    localparam int TEMP_W  = 17;
    localparam int LIMIT_W = 13;
    localparam int WORD_W  = 16;
    localparam int CNT_W   = 3;
    localparam int STAGE_W = 3;
    localparam int CODE_W  = 2;
    localparam int ERR_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    localparam logic signed [TEMP_W-1:0] KELVIN_OFFSET = 17'sd2732;

    localparam int FLAG_DSG_BIT = 0;
    localparam int FLAG_FC_BIT  = 9;
    localparam int FLAG_OTD_BIT = 14;
    localparam int FLAG_OTC_BIT = 15;

    localparam logic [WORD_W-1:0] LED_CAP_SPLIT = 16'd90;
    localparam logic [WORD_W-1:0] CAP_FULL      = 16'd100;

    localparam logic [CODE_W-1:0] ST_UNKNOWN     = 2'd0;
    localparam logic [CODE_W-1:0] ST_CHARGING    = 2'd1;
    localparam logic [CODE_W-1:0] ST_DISCHARGING = 2'd2;
    localparam logic [CODE_W-1:0] ST_FULL        = 2'd3;

    localparam logic [CODE_W-1:0] HL_UNKNOWN  = 2'd0;
    localparam logic [CODE_W-1:0] HL_GOOD     = 2'd1;
    localparam logic [CODE_W-1:0] HL_OVERHEAT = 2'd2;

    localparam int ERR_READ_BIT = 0;
    localparam int ERR_TEMP_BIT = 1;
    localparam int ERR_VOLT_BIT = 2;

    localparam logic [STAGE_W-1:0] STAGE_NONE = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_TEMP = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_VOLT = 3'd2;
    localparam logic [STAGE_W-1:0] STAGE_CURR = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_CAP  = 3'd4;
    localparam logic [STAGE_W-1:0] STAGE_FLAG = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_CRIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LED_EN    = 3'd7;

    typedef struct packed {
        logic                      slow_retry;
        logic                      shutdown_request;
        logic                      led_second_on;
        logic                      led_first_on;
        logic                      led_update;
        logic                      notify;
        logic                      reduce_charging;
        logic [ERR_W-1:0]          error_bits;
        logic [CODE_W-1:0]         health_code;
        logic [CODE_W-1:0]         charge_status;
        logic signed [TEMP_W-1:0]  temperature_dc;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/battery_poll_supervisor_unit.sv @@
// The result of an input transfer is registered and offered on the master side in the cycle after it.
// Throughput: one poll per cycle; the single output register sets the rate and
// a new poll is taken while a result waits, as long as m_tready drains it.
// Reset: rst_n asynchronous, active low; limits, stored readings, counters and
// sticky flags return to their reset values and the output register empties.
`default_nettype none

module battery_poll_supervisor_unit #(
    parameter int RETRY_LIMIT = 5
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [bps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bps_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // temp_raw, voltage_mv, current_ma, capacity_pct, gauge_flags,
    // fail_stage, vbus_present, zero fill
    input  wire logic [bps_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // temperature_dc, charge_status, health_code, error_bits, reduce_charging,
    // notify, led_update, led_first_on, led_second_on, shutdown_request,
    // slow_retry, zero fill
    output logic [bps_pkg::OUT_DATA_W-1:0]         m_tdata
);

    localparam logic [bps_pkg::CNT_W-1:0] RETRY_CODE = bps_pkg::CNT_W'(RETRY_LIMIT);

    logic signed [bps_pkg::LIMIT_W-1:0] temp_low_reg;
    logic signed [bps_pkg::LIMIT_W-1:0] temp_high_reg;
    logic signed [bps_pkg::LIMIT_W-1:0] temp_mid_reg;
    logic [bps_pkg::WORD_W-1:0]         volt_low_reg;
    logic [bps_pkg::WORD_W-1:0]         volt_high_reg;
    logic [bps_pkg::WORD_W-1:0]         volt_crit_reg;
    logic [bps_pkg::CNT_W-1:0]          range_lim_reg;
    logic                               led_en_reg;

    logic signed [bps_pkg::TEMP_W-1:0]  temp_store_reg, temp_store_next;
    logic [bps_pkg::WORD_W-1:0]         volt_store_reg, volt_store_next;
    logic signed [bps_pkg::WORD_W-1:0]  curr_store_reg, curr_store_next;
    logic [bps_pkg::WORD_W-1:0]         cap_store_reg, cap_store_next;
    logic [bps_pkg::CODE_W-1:0]         status_reg, status_next;
    logic [bps_pkg::CODE_W-1:0]         health_reg, health_next;
    logic [bps_pkg::CNT_W-1:0]          temp_bad_reg, temp_bad_next;
    logic [bps_pkg::CNT_W-1:0]          volt_bad_reg, volt_bad_next;
    logic [bps_pkg::CNT_W-1:0]          fail_cnt_reg, fail_cnt_next;
    logic [bps_pkg::ERR_W-1:0]          sticky_reg, sticky_next;
    logic                               reduce_reg, reduce_next;

    logic                               out_valid_reg;
    bps_pkg::result_t                   result_reg, result_next;

    logic signed [bps_pkg::WORD_W-1:0]  in_temp;
    logic [bps_pkg::WORD_W-1:0]         in_volt;
    logic signed [bps_pkg::WORD_W-1:0]  in_curr;
    logic [bps_pkg::WORD_W-1:0]         in_cap;
    logic [bps_pkg::WORD_W-1:0]         in_flags;
    logic [bps_pkg::STAGE_W-1:0]        in_stage;
    logic                               in_vbus;

    logic                               accept;
    logic                               temp_ok, volt_ok, curr_ok, cap_ok, flag_ok, failed;
    logic signed [bps_pkg::TEMP_W-1:0]  temp_dc;
    logic signed [bps_pkg::TEMP_W-1:0]  tlo, thi, tmid;
    logic [bps_pkg::CNT_W:0]            temp_inc, volt_inc;
    logic [bps_pkg::CNT_W-1:0]          fail_base, fail_inc;
    logic [bps_pkg::CODE_W-1:0]         status_calc, health_calc;
    logic                               changed, shutdown;
    logic                               led_upd, led_a, led_b;

    assign in_temp  = s_tdata[15:0];
    assign in_volt  = s_tdata[31:16];
    assign in_curr  = s_tdata[47:32];
    assign in_cap   = s_tdata[63:48];
    assign in_flags = s_tdata[79:64];
    assign in_stage = s_tdata[82:80];
    assign in_vbus  = s_tdata[83];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

    assign failed  = (in_stage != bps_pkg::STAGE_NONE);
    assign temp_ok = !failed || (in_stage > bps_pkg::STAGE_TEMP);
    assign volt_ok = !failed || (in_stage > bps_pkg::STAGE_VOLT);
    assign curr_ok = !failed || (in_stage > bps_pkg::STAGE_CURR);
    assign cap_ok  = !failed || (in_stage > bps_pkg::STAGE_CAP);
    assign flag_ok = !failed || (in_stage > bps_pkg::STAGE_FLAG);

    assign temp_dc = {in_temp[15], in_temp} - bps_pkg::KELVIN_OFFSET;
    assign tlo  = {{(bps_pkg::TEMP_W-bps_pkg::LIMIT_W){temp_low_reg[12]}}, temp_low_reg};
    assign thi  = {{(bps_pkg::TEMP_W-bps_pkg::LIMIT_W){temp_high_reg[12]}}, temp_high_reg};
    assign tmid = {{(bps_pkg::TEMP_W-bps_pkg::LIMIT_W){temp_mid_reg[12]}}, temp_mid_reg};

    always_comb
    begin
        temp_store_next = temp_store_reg;
        volt_store_next = volt_store_reg;
        curr_store_next = curr_store_reg;
        cap_store_next  = cap_store_reg;
        status_next     = status_reg;
        health_next     = health_reg;
        temp_bad_next   = temp_bad_reg;
        volt_bad_next   = volt_bad_reg;
        sticky_next     = sticky_reg;
        reduce_next     = reduce_reg;
        changed         = 1'b0;
        shutdown        = 1'b0;
        temp_inc        = '0;
        volt_inc        = '0;
        status_calc     = bps_pkg::ST_CHARGING;
        health_calc     = bps_pkg::HL_GOOD;
        fail_base       = fail_cnt_reg;

        if (temp_ok)
        begin
            if (temp_store_reg != temp_dc)
                changed = 1'b1;
            temp_store_next = temp_dc;
            fail_base = '0;
            if ((temp_dc <= tlo) || (temp_dc >= thi))
            begin
                temp_inc    = {1'b0, temp_bad_reg} + 4'd1;
                reduce_next = 1'b0;
            end
            else
            begin
                reduce_next = (temp_dc < tmid);
                sticky_next[bps_pkg::ERR_TEMP_BIT] = 1'b0;
            end
            if (temp_inc > {1'b0, range_lim_reg})
            begin
                sticky_next[bps_pkg::ERR_TEMP_BIT] = 1'b1;
                temp_bad_next = '0;
            end
            else
                temp_bad_next = temp_inc[bps_pkg::CNT_W-1:0];
        end

        if (volt_ok)
        begin
            if (volt_store_reg != in_volt)
                changed = 1'b1;
            volt_store_next = in_volt;
            shutdown = (in_volt <= volt_crit_reg);
            if ((in_volt <= volt_low_reg) || (in_volt >= volt_high_reg))
                volt_inc = {1'b0, volt_bad_reg} + 4'd1;
            else
                sticky_next[bps_pkg::ERR_VOLT_BIT] = 1'b0;
            if (volt_inc > {1'b0, range_lim_reg})
            begin
                sticky_next[bps_pkg::ERR_VOLT_BIT] = 1'b1;
                volt_bad_next = '0;
            end
            else
                volt_bad_next = volt_inc[bps_pkg::CNT_W-1:0];
        end

        if (curr_ok)
        begin
            if (curr_store_reg != in_curr)
                changed = 1'b1;
            curr_store_next = in_curr;
        end

        if (cap_ok)
        begin
            if (cap_store_reg != in_cap)
                changed = 1'b1;
            cap_store_next = in_cap;
        end

        if (flag_ok)
        begin
            priority if (in_flags[bps_pkg::FLAG_FC_BIT] && (cap_store_next == bps_pkg::CAP_FULL)
                         && (curr_store_next == '0))
                status_calc = bps_pkg::ST_FULL;
            else if (in_flags[bps_pkg::FLAG_DSG_BIT] || (curr_store_next <= 0))
                status_calc = bps_pkg::ST_DISCHARGING;
            else
                status_calc = bps_pkg::ST_CHARGING;
            if (in_flags[bps_pkg::FLAG_OTC_BIT] || in_flags[bps_pkg::FLAG_OTD_BIT])
                health_calc = bps_pkg::HL_OVERHEAT;
            if (status_reg != status_calc)
                changed = 1'b1;
            if (health_reg != health_calc)
                changed = 1'b1;
            status_next = status_calc;
            health_next = health_calc;
        end

        fail_inc = fail_base + 3'd1;
        if (failed)
        begin
            if (fail_inc == RETRY_CODE)
            begin
                sticky_next[bps_pkg::ERR_READ_BIT] = 1'b1;
                fail_cnt_next = '0;
            end
            else
                fail_cnt_next = fail_inc;
        end
        else
        begin
            sticky_next[bps_pkg::ERR_READ_BIT] = 1'b0;
            fail_cnt_next = '0;
        end

        led_upd = 1'b0;
        led_a   = 1'b0;
        led_b   = 1'b0;
        if (changed && led_en_reg)
        begin
            priority if ((status_next == bps_pkg::ST_CHARGING) && in_vbus)
            begin
                led_upd = 1'b1;
                led_a   = (cap_store_next >= bps_pkg::LED_CAP_SPLIT);
                led_b   = (cap_store_next < bps_pkg::LED_CAP_SPLIT);
            end
            else if (status_next == bps_pkg::ST_FULL)
            begin
                led_upd = 1'b1;
                led_a   = in_vbus;
            end
            else if (in_vbus)
                led_upd = 1'b1;
        end

        if (sticky_next[bps_pkg::ERR_READ_BIT])
            health_next = bps_pkg::HL_UNKNOWN;

        result_next.temperature_dc   = temp_store_next;
        result_next.charge_status    = status_next;
        result_next.health_code      = health_next;
        result_next.error_bits       = sticky_next;
        result_next.reduce_charging  = reduce_next;
        result_next.notify           = changed || sticky_next[bps_pkg::ERR_READ_BIT];
        result_next.led_update       = led_upd;
        result_next.led_first_on     = led_a;
        result_next.led_second_on    = led_b;
        result_next.shutdown_request = shutdown;
        result_next.slow_retry       = failed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_low_reg  <= 13'sd27;
            temp_high_reg <= 13'sd450;
            temp_mid_reg  <= 13'sd100;
            volt_low_reg  <= 16'd2500;
            volt_high_reg <= 16'd4350;
            volt_crit_reg <= 16'd3200;
            range_lim_reg <= 3'd4;
            led_en_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bps_pkg::REG_TEMP_LOW:  temp_low_reg  <= cfg_data[12:0];
                bps_pkg::REG_TEMP_HIGH: temp_high_reg <= cfg_data[12:0];
                bps_pkg::REG_TEMP_MID:  temp_mid_reg  <= cfg_data[12:0];
                bps_pkg::REG_VOLT_LOW:  volt_low_reg  <= cfg_data;
                bps_pkg::REG_VOLT_HIGH: volt_high_reg <= cfg_data;
                bps_pkg::REG_VOLT_CRIT: volt_crit_reg <= cfg_data;
                bps_pkg::REG_RANGE_LIM: range_lim_reg <= cfg_data[2:0];
                bps_pkg::REG_LED_EN:    led_en_reg    <= cfg_data[0];
                default:                led_en_reg    <= led_en_reg;
            endcase
        end
    end

    // advance poll state on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_store_reg <= '0;
            volt_store_reg <= 16'd3500;
            curr_store_reg <= '0;
            cap_store_reg  <= 16'd5;
            status_reg     <= bps_pkg::ST_UNKNOWN;
            health_reg     <= bps_pkg::HL_UNKNOWN;
            temp_bad_reg   <= '0;
            volt_bad_reg   <= '0;
            fail_cnt_reg   <= '0;
            sticky_reg     <= '0;
            reduce_reg     <= 1'b0;
        end
        else if (accept)
        begin
            temp_store_reg <= temp_store_next;
            volt_store_reg <= volt_store_next;
            curr_store_reg <= curr_store_next;
            cap_store_reg  <= cap_store_next;
            status_reg     <= status_next;
            health_reg     <= health_next;
            temp_bad_reg   <= temp_bad_next;
            volt_bad_reg   <= volt_bad_next;
            fail_cnt_reg   <= fail_cnt_next;
            sticky_reg     <= sticky_next;
            reduce_reg     <= reduce_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // hold the result until its transfer
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

`default_nettype wire

@@ tb/battery_poll_supervisor_unit_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none

module battery_poll_supervisor_unit_tb;

    localparam int READ_RETRY_LIMIT = 5;
    localparam int OUT_HOLD_CYCLES = 60;
    localparam int RUN_POLLS = 300;
    localparam int BURST_POLLS = 40;

    localparam logic [bps_pkg::STAGE_W-1:0] STAGE_LATER = 3'd6;
    localparam logic [bps_pkg::STAGE_W-1:0] STAGE_SPARE = 3'd7;

    localparam logic [bps_pkg::WORD_W-1:0] FLAG_DSG = 16'd1 << bps_pkg::FLAG_DSG_BIT;
    localparam logic [bps_pkg::WORD_W-1:0] FLAG_FC  = 16'd1 << bps_pkg::FLAG_FC_BIT;
    localparam logic [bps_pkg::WORD_W-1:0] FLAG_OTD = 16'd1 << bps_pkg::FLAG_OTD_BIT;
    localparam logic [bps_pkg::WORD_W-1:0] FLAG_OTC = 16'd1 << bps_pkg::FLAG_OTC_BIT;

    // fields from the lowest bit up: temp_raw, voltage_mv, current_ma,
    // capacity_pct, gauge_flags, fail_stage, vbus_present
    typedef struct packed {
        logic                               vbus_present;
        logic [bps_pkg::STAGE_W-1:0]        fail_stage;
        logic [bps_pkg::WORD_W-1:0]         gauge_flags;
        logic [bps_pkg::WORD_W-1:0]         capacity_pct;
        logic signed [bps_pkg::WORD_W-1:0]  current_ma;
        logic [bps_pkg::WORD_W-1:0]         voltage_mv;
        logic signed [bps_pkg::WORD_W-1:0]  temp_raw;
    } poll_t;

    typedef struct {
        int temp_low;
        int temp_high;
        int temp_mid;
        int volt_low;
        int volt_high;
        int volt_crit;
        int range_lim;
        int led_en;
    } limit_set_t;

    localparam limit_set_t LIMITS_DEFAULT = '{27, 450, 100, 2500, 4350, 3200, 4, 1};
    localparam limit_set_t LIMITS_OPEN    = '{-2732, 2000, 2000, 0, 65535, 65535, 7, 1};
    localparam limit_set_t LIMITS_CLOSED  = '{2000, -2732, -2732, 65535, 0, 0, 0, 0};

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    // temp_raw, voltage_mv, current_ma, capacity_pct, gauge_flags,
    // fail_stage, vbus_present, zero fill
    logic [bps_pkg::IN_DATA_W-1:0]   s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    // temperature_dc, charge_status, health_code, error_bits, reduce_charging,
    // notify, led_update, led_first_on, led_second_on, shutdown_request,
    // slow_retry, zero fill
    logic [bps_pkg::OUT_DATA_W-1:0]  m_tdata;

    logic signed [bps_pkg::LIMIT_W-1:0] lim_temp_low;
    logic signed [bps_pkg::LIMIT_W-1:0] lim_temp_high;
    logic signed [bps_pkg::LIMIT_W-1:0] lim_temp_mid;
    logic [bps_pkg::WORD_W-1:0]         lim_volt_low;
    logic [bps_pkg::WORD_W-1:0]         lim_volt_high;
    logic [bps_pkg::WORD_W-1:0]         lim_volt_crit;
    logic [bps_pkg::CNT_W-1:0]          lim_range;
    logic                               led_en;

    logic signed [bps_pkg::TEMP_W-1:0]  held_temp;
    logic [bps_pkg::WORD_W-1:0]         held_volt;
    logic signed [bps_pkg::WORD_W-1:0]  held_current;
    logic [bps_pkg::WORD_W-1:0]         held_capacity;
    logic [bps_pkg::CODE_W-1:0]         held_status;
    logic [bps_pkg::CODE_W-1:0]         held_health;
    int                                 temp_bad_run;
    int                                 volt_bad_run;
    logic [bps_pkg::CNT_W-1:0]          retry_run;
    logic [bps_pkg::ERR_W-1:0]          sticky_err;
    logic                               reduce_chg;

    bps_pkg::result_t results_due[$];
    int mismatch_count;
    int polls_sent;
    int results_seen;
    int settings_used;
    int send_idle_pct;
    int recv_idle_pct;
    logic out_hold;
    event out_hold_ev;

    battery_poll_supervisor_unit #(
        .RETRY_LIMIT (READ_RETRY_LIMIT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic void reset_supervisor_model();
        lim_temp_low  = 13'(LIMITS_DEFAULT.temp_low);
        lim_temp_high = 13'(LIMITS_DEFAULT.temp_high);
        lim_temp_mid  = 13'(LIMITS_DEFAULT.temp_mid);
        lim_volt_low  = 16'(LIMITS_DEFAULT.volt_low);
        lim_volt_high = 16'(LIMITS_DEFAULT.volt_high);
        lim_volt_crit = 16'(LIMITS_DEFAULT.volt_crit);
        lim_range     = 3'(LIMITS_DEFAULT.range_lim);
        led_en        = 1'(LIMITS_DEFAULT.led_en);
        held_temp     = '0;
        held_volt     = 16'd3500;
        held_current  = '0;
        held_capacity = 16'd5;
        held_status   = bps_pkg::ST_UNKNOWN;
        held_health   = bps_pkg::HL_UNKNOWN;
        temp_bad_run  = 0;
        volt_bad_run  = 0;
        retry_run     = '0;
        sticky_err    = '0;
        reduce_chg    = 1'b0;
    endfunction

    function automatic bps_pkg::result_t supervise_poll(input poll_t p);
        bps_pkg::result_t r;
        logic [bps_pkg::STAGE_W-1:0] stage;
        logic signed [bps_pkg::TEMP_W-1:0] t;
        logic go;
        logic changed;
        logic shutdown;
        logic led_upd;
        logic led_a;
        logic led_b;
        stage = (p.fail_stage == STAGE_SPARE) ? STAGE_LATER : p.fail_stage;
        changed = 1'b0;
        shutdown = 1'b0;
        led_upd = 1'b0;
        led_a = 1'b0;
        led_b = 1'b0;
        go = (stage != bps_pkg::STAGE_TEMP);
        if (go)
        begin
            t = $signed(p.temp_raw) - bps_pkg::KELVIN_OFFSET;
            if (t != held_temp)
            begin
                held_temp = t;
                changed = 1'b1;
            end
            retry_run = '0;
            if (t <= lim_temp_low || t >= lim_temp_high)
            begin
                temp_bad_run++;
                reduce_chg = 1'b0;
            end
            else
            begin
                reduce_chg = (t < lim_temp_mid);
                temp_bad_run = 0;
                sticky_err[bps_pkg::ERR_TEMP_BIT] = 1'b0;
            end
            if (temp_bad_run > lim_range)
            begin
                sticky_err[bps_pkg::ERR_TEMP_BIT] = 1'b1;
                temp_bad_run = 0;
            end
            go = (stage != bps_pkg::STAGE_VOLT);
        end
        if (go)
        begin
            if (p.voltage_mv != held_volt)
            begin
                held_volt = p.voltage_mv;
                changed = 1'b1;
            end
            shutdown = (p.voltage_mv <= lim_volt_crit);
            if (p.voltage_mv <= lim_volt_low || p.voltage_mv >= lim_volt_high)
                volt_bad_run++;
            else
            begin
                volt_bad_run = 0;
                sticky_err[bps_pkg::ERR_VOLT_BIT] = 1'b0;
            end
            if (volt_bad_run > lim_range)
            begin
                sticky_err[bps_pkg::ERR_VOLT_BIT] = 1'b1;
                volt_bad_run = 0;
            end
            go = (stage != bps_pkg::STAGE_CURR);
        end
        if (go)
        begin
            if ($signed(p.current_ma) != held_current)
            begin
                held_current = p.current_ma;
                changed = 1'b1;
            end
            go = (stage != bps_pkg::STAGE_CAP);
        end
        if (go)
        begin
            if (p.capacity_pct != held_capacity)
            begin
                held_capacity = p.capacity_pct;
                changed = 1'b1;
            end
            go = (stage != bps_pkg::STAGE_FLAG);
        end
        if (go)
        begin
            if (p.gauge_flags[bps_pkg::FLAG_FC_BIT] && held_capacity == bps_pkg::CAP_FULL
                && held_current == 0)
                r.charge_status = bps_pkg::ST_FULL;
            else if (p.gauge_flags[bps_pkg::FLAG_DSG_BIT] || held_current <= 0)
                r.charge_status = bps_pkg::ST_DISCHARGING;
            else
                r.charge_status = bps_pkg::ST_CHARGING;
            if (r.charge_status != held_status)
            begin
                held_status = r.charge_status;
                changed = 1'b1;
            end
            r.health_code = (p.gauge_flags[bps_pkg::FLAG_OTC_BIT] ||
                             p.gauge_flags[bps_pkg::FLAG_OTD_BIT]) ?
                            bps_pkg::HL_OVERHEAT : bps_pkg::HL_GOOD;
            if (r.health_code != held_health)
            begin
                held_health = r.health_code;
                changed = 1'b1;
            end
        end

        if (stage != bps_pkg::STAGE_NONE)
        begin
            retry_run++;
            if (retry_run == READ_RETRY_LIMIT)
            begin
                sticky_err[bps_pkg::ERR_READ_BIT] = 1'b1;
                retry_run = '0;
            end
        end
        else
        begin
            sticky_err[bps_pkg::ERR_READ_BIT] = 1'b0;
            retry_run = '0;
        end

        if (changed && led_en)
        begin
            if (held_status == bps_pkg::ST_CHARGING && p.vbus_present)
            begin
                led_upd = 1'b1;
                led_a = (held_capacity >= bps_pkg::LED_CAP_SPLIT);
                led_b = !led_a;
            end
            else if (held_status == bps_pkg::ST_FULL)
            begin
                led_upd = 1'b1;
                led_a = p.vbus_present;
            end
            else if (p.vbus_present)
                led_upd = 1'b1;
        end

        // dead battery: read failure masks health
        if (sticky_err[bps_pkg::ERR_READ_BIT])
            held_health = bps_pkg::HL_UNKNOWN;

        r.temperature_dc   = held_temp;
        r.charge_status    = held_status;
        r.health_code      = held_health;
        r.error_bits       = sticky_err;
        r.reduce_charging  = reduce_chg;
        r.notify           = changed || sticky_err[bps_pkg::ERR_READ_BIT];
        r.led_update       = led_upd;
        r.led_first_on     = led_a;
        r.led_second_on    = led_b;
        r.shutdown_request = shutdown;
        r.slow_retry       = (stage != bps_pkg::STAGE_NONE);
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge clk)
    begin
        bps_pkg::result_t got;
        bps_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bps_pkg::REG_TEMP_LOW:  lim_temp_low  = cfg_data[bps_pkg::LIMIT_W-1:0];
                    bps_pkg::REG_TEMP_HIGH: lim_temp_high = cfg_data[bps_pkg::LIMIT_W-1:0];
                    bps_pkg::REG_TEMP_MID:  lim_temp_mid  = cfg_data[bps_pkg::LIMIT_W-1:0];
                    bps_pkg::REG_VOLT_LOW:  lim_volt_low  = cfg_data;
                    bps_pkg::REG_VOLT_HIGH: lim_volt_high = cfg_data;
                    bps_pkg::REG_VOLT_CRIT: lim_volt_crit = cfg_data;
                    bps_pkg::REG_RANGE_LIM: lim_range     = cfg_data[bps_pkg::CNT_W-1:0];
                    bps_pkg::REG_LED_EN:    led_en        = cfg_data[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = bps_pkg::result_t'(m_tdata[$bits(bps_pkg::result_t)-1:0]);
                if (results_due.size() == 0)
                    flag_mismatch("result transfer with no poll outstanding");
                else
                begin
                    want = results_due.pop_front();
                    compare_field("temperature_dc", got.temperature_dc, want.temperature_dc);
                    compare_field("charge_status", got.charge_status, want.charge_status);
                    compare_field("health_code", got.health_code, want.health_code);
                    compare_field("error_bits", got.error_bits, want.error_bits);
                    compare_field("reduce_charging", got.reduce_charging,
                                  want.reduce_charging);
                    compare_field("notify", got.notify, want.notify);
                    compare_field("led_update", got.led_update, want.led_update);
                    compare_field("led_first_on", got.led_first_on, want.led_first_on);
                    compare_field("led_second_on", got.led_second_on, want.led_second_on);
                    compare_field("shutdown_request", got.shutdown_request,
                                  want.shutdown_request);
                    compare_field("slow_retry", got.slow_retry, want.slow_retry);
                end
            end
            if (s_tvalid && s_tready)
                results_due.push_back(supervise_poll(poll_t'(s_tdata[$bits(poll_t)-1:0])));
        end
    end

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        out_hold = 1'b0;
        forever
        begin
            @(out_hold_ev);
            out_hold <= 1'b1;
            repeat (OUT_HOLD_CYCLES) @(posedge clk);
            out_hold <= 1'b0;
        end
    end

    function automatic poll_t make_poll(input int temp, input int volt, input int cur,
                                        input int cap, input int flags,
                                        input logic [bps_pkg::STAGE_W-1:0] stage,
                                        input logic vbus);
        poll_t p;
        p.temp_raw     = 16'(temp);
        p.voltage_mv   = 16'(volt);
        p.current_ma   = 16'(cur);
        p.capacity_pct = 16'(cap);
        p.gauge_flags  = 16'(flags);
        p.fail_stage   = stage;
        p.vbus_present = vbus;
        return p;
    endfunction

    function automatic poll_t random_poll(input bit fail_heavy);
        poll_t p;
        int lo;
        int hi;
        int c;
        lo = lim_temp_low;
        hi = lim_temp_high;
        if (hi < lo)
        begin
            c = lo;
            lo = hi;
            hi = c;
        end
        if ($urandom_range(99) < 20)
            p.temp_raw = 16'($urandom);
        else
            p.temp_raw = 16'(lo - 80 + int'($urandom_range(hi - lo + 160))
                             + bps_pkg::KELVIN_OFFSET);

        lo = lim_volt_low;
        hi = lim_volt_high;
        if (hi < lo)
        begin
            c = lo;
            lo = hi;
            hi = c;
        end
        c = lo - 150 + int'($urandom_range(hi - lo + 300));
        if (c < 0)
            c = 0;
        if (c > 65535)
            c = 65535;
        p.voltage_mv = ($urandom_range(99) < 20) ? 16'($urandom) : 16'(c);

        case ($urandom_range(3))
            0: p.current_ma = '0;
            1: p.current_ma = 16'(int'($urandom_range(400)) - 200);
            default: p.current_ma = 16'($urandom);
        endcase

        case ($urandom_range(4))
            0: p.capacity_pct = bps_pkg::CAP_FULL;
            1: p.capacity_pct = 16'($urandom_range(80, 99));
            2: p.capacity_pct = 16'($urandom);
            default: p.capacity_pct = 16'($urandom_range(110));
        endcase

        if ($urandom_range(1))
            p.gauge_flags = 16'($urandom);
        else
        begin
            p.gauge_flags = '0;
            if ($urandom_range(1))
                p.gauge_flags |= FLAG_DSG;
            if ($urandom_range(1))
                p.gauge_flags |= FLAG_FC;
            if ($urandom_range(3) == 0)
                p.gauge_flags |= FLAG_OTD;
            if ($urandom_range(3) == 0)
                p.gauge_flags |= FLAG_OTC;
        end

        if ($urandom_range(99) < (fail_heavy ? 85 : 12))
            p.fail_stage = 3'($urandom_range(bps_pkg::STAGE_TEMP, STAGE_SPARE));
        else
            p.fail_stage = bps_pkg::STAGE_NONE;
        p.vbus_present = 1'($urandom_range(1));
        return p;
    endfunction

    function automatic limit_set_t random_limits();
        limit_set_t s;
        s.temp_low  = int'($urandom_range(500)) - 300;
        s.temp_high = s.temp_low + int'($urandom_range(1, 700));
        s.temp_mid  = s.temp_low + int'($urandom_range(s.temp_high - s.temp_low + 50));
        s.volt_low  = $urandom_range(2000, 3500);
        s.volt_high = s.volt_low + int'($urandom_range(200, 1500));
        s.volt_crit = $urandom_range(s.volt_low, s.volt_high);
        s.range_lim = $urandom_range(7);
        s.led_en    = $urandom_range(1);
        return s;
    endfunction

    task automatic send_poll(input poll_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= bps_pkg::IN_DATA_W'(p);
        do
            @(posedge clk);
        while (!s_tready);
        polls_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bps_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[bps_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic apply_limits(input limit_set_t s);
        wait_drained();
        write_reg(bps_pkg::REG_TEMP_LOW, s.temp_low);
        write_reg(bps_pkg::REG_TEMP_HIGH, s.temp_high);
        write_reg(bps_pkg::REG_TEMP_MID, s.temp_mid);
        write_reg(bps_pkg::REG_VOLT_LOW, s.volt_low);
        write_reg(bps_pkg::REG_VOLT_HIGH, s.volt_high);
        write_reg(bps_pkg::REG_VOLT_CRIT, s.volt_crit);
        write_reg(bps_pkg::REG_RANGE_LIM, s.range_lim);
        write_reg(bps_pkg::REG_LED_EN, s.led_en);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_setting(input limit_set_t s, input int count);
        bit fail_heavy;
        apply_limits(s);
        fail_heavy = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            // switch between healthy and failing stretches to reach the retry limit
            if (i % 16 == 0)
                fail_heavy = ($urandom_range(3) == 0);
            send_poll(random_poll(fail_heavy));
        end
    endtask

    task automatic test_field_extremes();
        send_poll(make_poll(0, 0, 0, 0, 0, bps_pkg::STAGE_NONE, 1'b0));
        send_poll(make_poll(32767, 65535, 32767, 65535, 65535, bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(-32768, 0, -32768, 0, 0, bps_pkg::STAGE_NONE, 1'b0));
        send_poll(make_poll(2982, 3800, 500, 60, 0, bps_pkg::STAGE_NONE, 1'b1));
    endtask

    task automatic test_status_and_leds();
        send_poll(make_poll(2782, 3800, 800, 50, 0, bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(2982, 4000, 300, 95, 0, bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(2982, 4200, 0, bps_pkg::CAP_FULL, FLAG_FC,
                            bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(2990, 4200, 0, bps_pkg::CAP_FULL, FLAG_FC,
                            bps_pkg::STAGE_NONE, 1'b0));
        send_poll(make_poll(3000, 3100, 200, 40, FLAG_DSG, bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(3300, 3700, -100, 40, FLAG_OTC, bps_pkg::STAGE_NONE, 1'b0));
        send_poll(make_poll(3200, 3700, -100, 40, FLAG_OTD, bps_pkg::STAGE_NONE, 1'b1));
        send_poll(make_poll(3200, 3700, -100, 40, FLAG_OTD, bps_pkg::STAGE_NONE, 1'b1));
    endtask

    task automatic test_fail_stages();
        for (int s = bps_pkg::STAGE_TEMP; s <= STAGE_SPARE; s++)
            send_poll(make_poll(2900 + s, 3000 + 100 * s, s, 50 + s, FLAG_DSG, 3'(s), 1'b1));
    endtask

    task automatic test_retry_limit();
        send_poll(make_poll(2950, 3900, 150, 70, 0, bps_pkg::STAGE_NONE, 1'b1));
        repeat (READ_RETRY_LIMIT)
            send_poll(make_poll(2960, 3950, 160, 71, 0, bps_pkg::STAGE_TEMP, 1'b1));
        send_poll(make_poll(2970, 3960, 170, 72, 0, bps_pkg::STAGE_NONE, 1'b1));
    endtask

    task automatic test_sender_light_receiver_heavy();
        send_idle_pct = 23;
        recv_idle_pct = 88;
        run_setting(LIMITS_OPEN, RUN_POLLS);
        run_setting(random_limits(), RUN_POLLS);
    endtask

    task automatic test_sender_heavy_receiver_light();
        send_idle_pct = 88;
        recv_idle_pct = 23;
        run_setting(LIMITS_CLOSED, RUN_POLLS);
        run_setting(random_limits(), RUN_POLLS);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(random_limits(), RUN_POLLS);
        run_setting(LIMITS_DEFAULT, RUN_POLLS);
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_drained();
        -> out_hold_ev;
        repeat (BURST_POLLS)
            send_poll(random_poll(1'b0));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        mismatch_count = 0;
        polls_sent = 0;
        results_seen = 0;
        settings_used = 0;
        send_idle_pct = 23;
        recv_idle_pct = 88;
        reset_supervisor_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_status_and_leds();
        test_fail_stages();
        test_retry_limit();
        test_sender_light_receiver_heavy();
        test_sender_heavy_receiver_light();
        test_no_idle();
        test_output_hold();
        wait_drained();

        $display("Covered %0d polls and %0d results over %0d limit settings: all fail stages,",
                 polls_sent, results_seen, settings_used);
        $display("retry and range counters, LED paths, three idle mixes, a %0d-cycle output hold.",
                 OUT_HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
